// File: hw/rtl/ctq_pkg.sv
// ============================================================================
// ctq_pkg
// Shared request and response types and command codes for the coalescing
// timer queue.
// ============================================================================
package ctq_pkg;

    typedef enum logic [1:0] {
        CMD_ARM    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    localparam logic CFG_TOL_LOW_POWER = 1'b0;
    localparam logic CFG_TOL_PRECISE   = 1'b1;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  timer_id;
        logic [63:0] time_value;
        logic [63:0] period_time;
        logic        low_power;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        armed;
        logic        expired_valid;
        logic [3:0]  expired_id;
        logic        reschedule;
        logic [63:0] next_deadline;
        logic        last;
    } t_rsp;

endpackage

// File: hw/rtl/ctq_ram.sv
// ============================================================================
// ctq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module ctq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/coalescing_timer_queue.sv
// ============================================================================
// coalescing_timer_queue
// Sorted timer queue with slack coalescing, kept in one timer RAM.
// ============================================================================
// A request is taken at a clock edge where start is high and busy is low.
// Every request gives one or more responses on o_rsp, each marked by o_valid
// for exactly one cycle; the final one has last set. The receiver cannot
// stall, so responses stream out on consecutive cycles.
// Query, refused arm and cancel of an idle timer answer in the cycle after the
// request and keep busy low. Every other request walks the timer RAM, one
// entry per cycle through its single read port, in passes over all entries:
// arm takes two passes, cancel two passes. A tick checks the head, and for
// each expired timer reads its data, runs a removal pass, an insertion pass
// and a write for a periodic timer and a head pass, then checks again;
// finally it gives its responses. Timer alarms, periods, classes and queue
// positions live in the RAM; armed flags and the head deadline live in flops.
// After reset no timer is armed, the deadline reads all ones and the slack
// registers hold their defaults; the RAM needs no clearing pass.
// Configuration writes on the i_cfg port take effect at the next edge.
// ============================================================================
module coalescing_timer_queue #(
    parameter int NUM_TIMERS = 16,
    parameter int MAX_EXPIRE = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ctq_pkg::t_req i_req,
    output logic          o_valid,
    output ctq_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    import ctq_pkg::*;

    localparam int IW  = $clog2(NUM_TIMERS);
    localparam int CW  = $clog2(NUM_TIMERS + 1);
    localparam int CAP = (MAX_EXPIRE < 32) ? MAX_EXPIRE : 32;
    localparam int NW  = $clog2(CAP + 1);
    localparam int BW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int EW  = 64 + 64 + 1 + IW;

    typedef struct packed {
        logic [63:0]   alarm;
        logic [63:0]   period;
        logic          cls;
        logic [IW-1:0] rank;
    } t_ent;

    typedef enum logic [2:0] {
        S_IDLE, S_CDAT, S_TCHK, S_TDAT, S_SCAN, S_FIN, S_DONE, S_TOUT
    } t_state;

    typedef enum logic [1:0] {
        P_ENQ, P_REM, P_HEAD
    } t_pass;

    t_state          r_state;
    t_pass           r_pass;
    t_cmd            r_cmd;
    logic [31:0]     r_tol_lp;
    logic [31:0]     r_tol_pr;
    logic [NUM_TIMERS-1:0] r_inq;
    logic            r_head_vld;
    logic [63:0]     r_head_alarm;
    logic [IW-1:0]   r_head_id;
    logic [IW-1:0]   r_t;
    logic [63:0]     r_a;
    logic [63:0]     r_per;
    logic            r_cls;
    logic [63:0]     r_tv;
    logic [IW-1:0]   r_r;
    logic [CW-1:0]   r_sc;
    logic            r_pv;
    logic [IW-1:0]   r_pidx;
    logic [IW-1:0]   r_le_cnt;
    logic [63:0]     r_min;
    logic            r_min_vld;
    logic            r_rs;
    logic [NW-1:0]   r_n;
    logic [NW-1:0]   r_e;
    logic [3:0]      r_buf [CAP];

    logic            w_id_ok;
    logic [IW-1:0]   w_id;
    t_ent            w_q;
    logic            w_pin;
    logic            w_le;
    logic [31:0]     w_tol;
    logic [63:0]     w_diff;
    logic            w_snap;
    logic [64:0]     w_sum;
    logic [63:0]     w_sat;
    logic [63:0]     w_nd;
    logic            w_we;
    logic [IW-1:0]   w_waddr;
    t_ent            w_wdata;
    logic [IW-1:0]   w_raddr;
    logic [EW-1:0]   w_rdata;

    assign w_id_ok = 32'(i_req.timer_id) < 32'(NUM_TIMERS);
    assign w_id    = IW'(i_req.timer_id);
    assign w_q     = t_ent'(w_rdata);
    assign w_pin   = r_pv && r_inq[r_pidx];
    assign w_le    = w_q.alarm <= r_a;
    assign w_tol   = r_cls ? r_tol_lp : r_tol_pr;
    assign w_diff  = r_min - r_a;
    assign w_snap  = r_min_vld && (w_diff <= {32'd0, w_tol});
    assign w_sum   = {1'b0, w_q.alarm} + {1'b0, w_q.period};
    assign w_sat   = w_sum[64] ? ALL_ONES : w_sum[63:0];
    assign w_nd    = r_head_vld ? r_head_alarm : ALL_ONES;
    assign busy    = (r_state != S_IDLE);

    // read-modify-write of the timer entries
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pidx;
        w_wdata = w_q;
        if (r_state == S_SCAN && w_pin) begin
            if (r_pass == P_ENQ && !w_le) begin
                w_we         = 1'b1;
                w_wdata.rank = w_q.rank + IW'(1);
            end else if (r_pass == P_REM && w_q.rank > r_r) begin
                w_we         = 1'b1;
                w_wdata.rank = w_q.rank - IW'(1);
            end
        end else if (r_state == S_FIN) begin
            w_we           = 1'b1;
            w_waddr        = r_t;
            w_wdata.alarm  = w_snap ? r_min : r_a;
            w_wdata.period = r_per;
            w_wdata.cls    = r_cls;
            w_wdata.rank   = r_le_cnt;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  w_raddr = w_id;
            S_TCHK:  w_raddr = r_head_id;
            S_SCAN:  w_raddr = r_sc[IW-1:0];
            default: w_raddr = r_t;
        endcase
    end

    ctq_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (EW'(w_wdata)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pass       <= P_HEAD;
            r_cmd        <= CMD_ARM;
            r_tol_lp     <= 32'd1000000000;
            r_tol_pr     <= 32'd0;
            r_inq        <= '0;
            r_head_vld   <= 1'b0;
            r_head_alarm <= ALL_ONES;
            r_head_id    <= '0;
            r_pv         <= 1'b0;
            r_sc         <= '0;
            r_n          <= '0;
            r_e          <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOL_LOW_POWER: r_tol_lp <= i_cfg_data;
                    CFG_TOL_PRECISE:   r_tol_pr <= i_cfg_data;
                    default:           r_tol_pr <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd  <= t_cmd'(i_req.command);
                        r_t    <= w_id;
                        r_a    <= i_req.time_value;
                        r_per  <= i_req.period_time;
                        r_cls  <= i_req.low_power;
                        r_tv   <= i_req.time_value;
                        o_rsp  <= '{status: (t_cmd'(i_req.command) == CMD_ARM)
                                            && (!w_id_ok || r_inq[w_id]),
                                   armed: (t_cmd'(i_req.command) == CMD_QUERY)
                                          && w_id_ok && r_inq[w_id],
                                   expired_valid: 1'b0,
                                   expired_id: 4'd0, reschedule: 1'b0,
                                   next_deadline: w_nd, last: 1'b1};
                        unique case (t_cmd'(i_req.command))
                            CMD_ARM: begin
                                if (!w_id_ok || r_inq[w_id]) begin
                                    o_valid <= 1'b1;
                                end else begin
                                    r_pass    <= P_ENQ;
                                    r_sc      <= '0;
                                    r_pv      <= 1'b0;
                                    r_le_cnt  <= '0;
                                    r_min     <= ALL_ONES;
                                    r_min_vld <= 1'b0;
                                    r_state   <= S_SCAN;
                                end
                            end
                            CMD_CANCEL: begin
                                if (w_id_ok && r_inq[w_id]) begin
                                    r_state <= S_CDAT;
                                end else begin
                                    o_valid <= 1'b1;
                                end
                            end
                            CMD_QUERY: begin
                                o_valid <= 1'b1;
                            end
                            CMD_TICK: begin
                                r_n     <= '0;
                                r_state <= S_TCHK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CDAT: begin
                    r_r        <= w_q.rank;
                    r_inq[r_t] <= 1'b0;
                    r_pass     <= P_REM;
                    r_sc       <= '0;
                    r_pv       <= 1'b0;
                    r_state    <= S_SCAN;
                end
                S_TCHK: begin
                    if (r_head_vld && r_head_alarm <= r_tv && r_n < NW'(CAP)) begin
                        r_buf[r_n[BW-1:0]] <= 4'(r_head_id);
                        r_n     <= r_n + NW'(1);
                        r_t     <= r_head_id;
                        r_state <= S_TDAT;
                    end else begin
                        r_e     <= '0;
                        r_state <= S_TOUT;
                    end
                end
                S_TDAT: begin
                    r_r        <= '0;
                    r_inq[r_t] <= 1'b0;
                    r_per      <= w_q.period;
                    r_cls      <= w_q.cls;
                    r_a        <= w_sat;
                    r_pass     <= P_REM;
                    r_sc       <= '0;
                    r_pv       <= 1'b0;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_sc < CW'(NUM_TIMERS)) begin
                        r_sc   <= r_sc + CW'(1);
                        r_pv   <= 1'b1;
                        r_pidx <= r_sc[IW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (w_pin) begin
                        if (r_pass == P_ENQ) begin
                            if (w_le) begin
                                r_le_cnt <= r_le_cnt + IW'(1);
                            end else if (w_q.alarm < r_min || !r_min_vld) begin
                                r_min     <= w_q.alarm;
                                r_min_vld <= 1'b1;
                            end
                        end else if (r_pass == P_HEAD && w_q.rank == '0) begin
                            r_head_vld   <= 1'b1;
                            r_head_alarm <= w_q.alarm;
                            r_head_id    <= r_pidx;
                        end
                    end
                    if (r_sc == CW'(NUM_TIMERS)) begin
                        r_sc <= '0;
                        r_pv <= 1'b0;
                        if (r_pass == P_ENQ) begin
                            r_state <= S_FIN;
                        end else if (r_pass == P_REM && r_cmd == CMD_TICK
                                     && r_per != ALL_ONES) begin
                            r_pass    <= P_ENQ;
                            r_le_cnt  <= '0;
                            r_min     <= ALL_ONES;
                            r_min_vld <= 1'b0;
                        end else if (r_pass == P_REM) begin
                            r_pass       <= P_HEAD;
                            r_head_vld   <= 1'b0;
                            r_head_alarm <= ALL_ONES;
                            r_head_id    <= '0;
                        end else begin
                            r_state <= (r_cmd == CMD_TICK) ? S_TCHK : S_DONE;
                        end
                    end
                end
                S_FIN: begin
                    r_inq[r_t]   <= 1'b1;
                    r_rs         <= (r_le_cnt == '0) && !w_snap;
                    r_pass       <= P_HEAD;
                    r_sc         <= '0;
                    r_pv         <= 1'b0;
                    r_head_vld   <= 1'b0;
                    r_head_alarm <= ALL_ONES;
                    r_head_id    <= '0;
                    r_state      <= S_SCAN;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_rsp   <= '{status: 1'b0, armed: 1'b0, expired_valid: 1'b0,
                                 expired_id: 4'd0,
                                 reschedule: (r_cmd == CMD_ARM) && r_rs,
                                 next_deadline: w_nd, last: 1'b1};
                    r_state <= S_IDLE;
                end
                S_TOUT: begin
                    o_valid <= 1'b1;
                    if (r_n == '0) begin
                        o_rsp   <= '{status: 1'b0, armed: 1'b0, expired_valid: 1'b0,
                                     expired_id: 4'd0, reschedule: 1'b0,
                                     next_deadline: w_nd, last: 1'b1};
                        r_state <= S_IDLE;
                    end else begin
                        o_rsp <= '{status: 1'b0, armed: 1'b0, expired_valid: 1'b1,
                                   expired_id: r_buf[r_e[BW-1:0]], reschedule: 1'b0,
                                   next_deadline: w_nd,
                                   last: (r_e == r_n - NW'(1))};
                        r_e <= r_e + NW'(1);
                        if (r_e == r_n - NW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ram_write_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_SCAN || r_state == S_FIN))
        else $error("timer ram written outside a pass");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending ram read left in idle");

    a_head_matches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_head_vld == (|r_inq)))
        else $error("head flag disagrees with armed timers");

    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.last) |=> o_valid)
        else $error("response burst broken");

    a_expiry_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(CAP))
        else $error("expiry count beyond cap");

endmodule
